@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/stdt_pkg.sv @@
// types, constants and helpers of the dedup table
`default_nettype none
package stdt_pkg;

   localparam int DEPTH     = 64;
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W     = 7;
   localparam int SUM_W     = CNT_W + 1;
   localparam int LABEL_W   = 8;
   localparam int POS_W     = 20;
   localparam int DIFF_W    = POS_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int TIME_W    = 32;
   localparam int LIMIT_W   = 7;
   localparam int XY_W      = 16;
   localparam int Z_W       = 16;
   localparam int COOL_W    = 22;
   localparam int EXP_W     = COOL_W + 2;
   localparam int LIM2_W    = 2 * XY_W;
   localparam int CSR_W     = 22;
   localparam int CSR_IDX_W = 2;

   localparam logic [EXP_W-1:0] EXPIRY_FLOOR_MS = EXP_W'(20000);
   localparam logic [EXP_W-1:0] EXPIRY_FACTOR   = EXP_W'(3);

   localparam logic              RESET_ENABLE   = 1'b1;
   localparam logic [XY_W-1:0]   RESET_MAX_XY   = XY_W'(550);
   localparam logic [Z_W-1:0]    RESET_MAX_Z    = Z_W'(350);
   localparam logic [COOL_W-1:0] RESET_COOLDOWN = COOL_W'(8000);

   typedef enum logic [0:0] {
      OP_CHECK    = 1'b0,
      OP_REMEMBER = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_PASS     = 2'd0,
      KIND_CHECK    = 2'd1,
      KIND_REMEMBER = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_MAX_XY   = 2'd1,
      CSR_MAX_Z    = 2'd2,
      CSR_COOLDOWN = 2'd3
   } csr_idx_type;

   typedef struct packed {
      op_type                   op;
      logic [LABEL_W-1:0]       label_id;
      logic signed [POS_W-1:0]  pos_x_mm;
      logic signed [POS_W-1:0]  pos_y_mm;
      logic signed [POS_W-1:0]  pos_z_mm;
      logic [TIME_W-1:0]        time_now_ms;
      logic [LIMIT_W-1:0]       check_limit;
   } req_type;

   typedef struct packed {
      logic             is_duplicate;
      logic [CNT_W-1:0] stored_count;
      logic             oldest_dropped;
   } rsp_type;

   typedef struct packed {
      logic              dedup_enable;
      logic [XY_W-1:0]   max_delta_xy_mm;
      logic [Z_W-1:0]    max_delta_z_mm;
      logic [COOL_W-1:0] cooldown_ms;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      req_type  item;
   } cmd_type;

   typedef struct packed {
      logic [LABEL_W-1:0]      label;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [TIME_W-1:0]       stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] s;
      s = SUM_W'(head) + SUM_W'(offset);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/stdt_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module stdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/stdt_front.sv @@
// front end: accepts transactions, classifies them and queues them
`default_nettype none
module stdt_front
   import stdt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   input  wire cfg_type cfg,
   input  wire logic    q_pop,
   output logic         q_valid,
   output cmd_type      q_cmd
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;
   cmd_type           new_cmd;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign busy    = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign q_valid = (fill_ff != '0);
   assign q_cmd   = slot_ff[rd_ptr_ff];
   assign push    = start && !busy;
   assign pop     = q_pop && q_valid;

   always_comb begin
      new_cmd.item = req_item;
      priority if (req_item.op == OP_REMEMBER) begin
         new_cmd.kind = KIND_REMEMBER;
      end else if (cfg.dedup_enable && (req_item.check_limit != '0)) begin
         new_cmd.kind = KIND_CHECK;
      end else begin
         new_cmd.kind = KIND_PASS;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule
`default_nettype wire

@@ rtl/stdt_back.sv @@
// back end: ring store, pipelined match scan and expiry sequencer
`default_nettype none
module stdt_back
   import stdt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    q_valid,
   input  wire cmd_type q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_DRAIN   = 5'b00100,
      ST_EXP_RD  = 5'b01000,
      ST_EXP_CMP = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              dup_ff, dup_in;
   logic              dropped_ff, dropped_in;
   req_type           item_ff, item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [LIM2_W-1:0] lim2_ff;
   logic [EXP_W-1:0]  expiry_ff;
   logic [EXP_W-1:0]  expiry_raw;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_entry;
   logic              rd_en;
   logic              issue;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd_entry;

   logic                     v0_ff;
   logic                     s1_valid_ff, s1_ok_ff;
   logic signed [DIFF_W-1:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic                     s2_valid_ff, s2_ok_ff;
   logic [SQ_W-1:0]          s2_sqx_ff, s2_sqy_ff;

   logic [TIME_W-1:0]        scan_age;
   logic [TIME_W-1:0]        exp_age;
   logic signed [DIFF_W-1:0] dx, dy, dz;
   logic signed [SQ_W-1:0]   sqx, sqy;
   logic [DIFF_W-1:0]        adz;
   logic [SQ_W:0]            d2;
   logic                     hit;
   logic                     full;
   logic [CNT_W-1:0]         scan_n;

   stdt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign expiry_raw = EXP_W'(cfg.cooldown_ms) * EXPIRY_FACTOR;

   always_ff @(posedge clock) begin
      lim2_ff   <= LIM2_W'(cfg.max_delta_xy_mm) * LIM2_W'(cfg.max_delta_xy_mm);
      expiry_ff <= (expiry_raw < EXPIRY_FLOOR_MS) ? EXPIRY_FLOOR_MS : expiry_raw;
   end

   // scan pipeline
   assign scan_age = item_ff.time_now_ms - rd_entry.stamp;
   assign dx  = $signed({item_ff.pos_x_mm[POS_W-1], item_ff.pos_x_mm})
              - $signed({rd_entry.x[POS_W-1], rd_entry.x});
   assign dy  = $signed({item_ff.pos_y_mm[POS_W-1], item_ff.pos_y_mm})
              - $signed({rd_entry.y[POS_W-1], rd_entry.y});
   assign dz  = $signed({item_ff.pos_z_mm[POS_W-1], item_ff.pos_z_mm})
              - $signed({rd_entry.z[POS_W-1], rd_entry.z});
   assign sqx = s1_dx_ff * s1_dx_ff;
   assign sqy = s1_dy_ff * s1_dy_ff;
   assign adz = s1_dz_ff[DIFF_W-1] ? DIFF_W'(-s1_dz_ff) : DIFF_W'(s1_dz_ff);
   assign d2  = (SQ_W+1)'(s2_sqx_ff) + (SQ_W+1)'(s2_sqy_ff);
   assign hit = s2_valid_ff && s2_ok_ff && (d2 <= (SQ_W+1)'(lim2_ff));

   always_ff @(posedge clock) begin
      s1_ok_ff  <= (rd_entry.label == item_ff.label_id)
                && (scan_age <= TIME_W'(cfg.cooldown_ms));
      s1_dx_ff  <= dx;
      s1_dy_ff  <= dy;
      s1_dz_ff  <= dz;
      s2_ok_ff  <= s1_ok_ff && (adz <= DIFF_W'(cfg.max_delta_z_mm));
      s2_sqx_ff <= SQ_W'(unsigned'(sqx));
      s2_sqy_ff <= SQ_W'(unsigned'(sqy));
   end

   assign exp_age = item_ff.time_now_ms - rd_entry.stamp;
   assign full    = (count_ff >= CNT_W'(DEPTH));
   assign scan_n  = (q_cmd.item.check_limit < count_ff) ? q_cmd.item.check_limit : count_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      dup_in       = dup_ff || hit;
      dropped_in   = dropped_ff;
      item_in      = item_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = wrap_add(head_ff, count_ff);
      wr_entry.label = q_cmd.item.label_id;
      wr_entry.x     = q_cmd.item.pos_x_mm;
      wr_entry.y     = q_cmd.item.pos_y_mm;
      wr_entry.z     = q_cmd.item.pos_z_mm;
      wr_entry.stamp = q_cmd.item.time_now_ms;
      issue        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = wrap_add(head_ff, idx_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in = q_cmd.item;
               unique case (q_cmd.kind)
                  KIND_CHECK: begin
                     if (scan_n == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{1'b0, count_ff, 1'b0};
                     end else begin
                        n_in     = scan_n;
                        idx_in   = '0;
                        dup_in   = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  KIND_REMEMBER: begin
                     wr_en = 1'b1;
                     if (full) begin
                        wr_addr = head_ff;
                        head_in = wrap_add(head_ff, CNT_W'(1));
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                     dropped_in = full;
                     state_in   = ST_EXP_RD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{1'b0, count_ff, 1'b0};
                  end
               endcase
            end
         end
         ST_SCAN: begin
            issue  = 1'b1;
            rd_en  = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (CNT_W'(idx_ff + 1'b1) == n_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v0_ff && !s1_valid_ff && !s2_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{dup_ff, count_ff, 1'b0};
               state_in     = ST_IDLE;
            end
         end
         ST_EXP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = ST_EXP_CMP;
         end
         ST_EXP_CMP: begin
            if (exp_age > TIME_W'(expiry_ff)) begin
               head_in  = wrap_add(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
               state_in = ST_EXP_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{1'b0, count_ff, dropped_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v0_ff        <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         v0_ff        <= issue;
         s1_valid_ff  <= v0_ff;
         s2_valid_ff  <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      dup_ff     <= dup_in;
      dropped_ff <= dropped_in;
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire

@@ rtl/spatial_temporal_dedup_table.sv @@
// top level of the spatial-temporal dedup table: config registers, front and back
// a pass, or a check that scans nothing, is answered straight from idle; a check
// over n entries reads one ring entry per cycle, then drains the match pipeline
// before its strobe; a remember writes its entry, then reads and pops expired
// head entries; a new transaction is taken only when idle; results cannot stall
// synchronous reset clears pointers, queue and strobes and restores config defaults
`default_nettype none
`include "assert_macros.svh"
module spatial_temporal_dedup_table
   import stdt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_item,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ENABLE:   cfg_in.dedup_enable    = csr_wdata[0];
            CSR_MAX_XY:   cfg_in.max_delta_xy_mm = csr_wdata[XY_W-1:0];
            CSR_MAX_Z:    cfg_in.max_delta_z_mm  = csr_wdata[Z_W-1:0];
            CSR_COOLDOWN: cfg_in.cooldown_ms     = csr_wdata[COOL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RESET_ENABLE, RESET_MAX_XY, RESET_MAX_Z, RESET_COOLDOWN};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stdt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .q_pop    (q_pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   stdt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `ASSERT_IMPLIES(a_dup_not_dropped, rsp_valid, !(rsp_data.is_duplicate && rsp_data.oldest_dropped), "duplicate and drop flagged together")
   `ASSERT_IMPLIES(a_count_bound, rsp_valid, rsp_data.stored_count <= CNT_W'(DEPTH), "stored count beyond depth")
   `ASSERT_IMPLIES(a_dup_needs_entry, rsp_valid && rsp_data.is_duplicate, rsp_data.stored_count != '0, "duplicate reported on empty store")
   `ASSERT_NEXT(a_pop_only_valid, q_pop, !q_pop || q_valid, "queue popped while empty")

endmodule
`default_nettype wire
